/* hdl/cumm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cumm_pkg
// Shared types and constants for the cluster usage map marker.
// ----------------------------------------------------------------------------
package cumm_pkg;

    // operation codes
    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int ADDR_W    = 33;   // partition base, offset, length
    localparam int IMAGE_W   = 34;   // image size register
    localparam int START_W   = 35;   // raw start position
    localparam int STOP_W    = 36;   // raw end position
    localparam int QIDX_W    = 18;   // query cluster port
    localparam int IDX_W     = 20;   // cluster index taken from a position
    localparam int COUNT_W   = 19;

    localparam int CLUSTER_SHIFT = 15;
    localparam int PAYLOAD_SHIFT = 10;   // 0x7C00 = 31 << 10

    localparam logic [START_W-1:0] CLUSTER_BYTES = START_W'(36'h0_0000_8000);
    localparam logic [IMAGE_W-1:0] IMAGE_LIMIT   = 34'h2_0000_0000;

    // divide by 31 via reciprocal: q0 = (x * RECIP_31) >> RECIP_SHIFT, low by at most one
    localparam int              DIVX_W      = ADDR_W - PAYLOAD_SHIFT;   // 23
    localparam int              RECIP_W     = 21;
    localparam int              PROD_W      = DIVX_W + RECIP_W;         // 44
    localparam int              RECIP_SHIFT = 25;
    localparam logic [RECIP_W-1:0] RECIP_31 = 21'd1082401;
    localparam logic [5:0]      DIV_31      = 6'd31;

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic               is_query;
        logic [START_W-1:0] start;   // query: cluster index in the cluster field
        logic [STOP_W-1:0]  stop;
    } cumm_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cumm_qstat_t;

endpackage
`default_nettype wire

/* hdl/cumm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cumm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cumm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hdl/cumm_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cumm_fifo
// Short request queue decoupling the front classifier from the back walker.
// ----------------------------------------------------------------------------
module cumm_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire cumm_pkg::cumm_req_t wdata,
    input  wire logic                pop,
    output cumm_pkg::cumm_req_t      head,
    output cumm_pkg::cumm_qstat_t    status
);

    localparam int QD = cumm_pkg::QDEPTH;
    localparam int PW = cumm_pkg::QPTR_W;

    cumm_pkg::cumm_req_t slot_reg [QD];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == (PW+1)'(QD));
    assign status.empty = (fill_reg == '0);

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("request pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("request popped from an empty queue");

endmodule
`default_nettype wire

/* hdl/cumm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cumm_front
// Takes requests and turns each into a raw start/stop range or a query.
// ----------------------------------------------------------------------------
module cumm_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              operation,
    input  wire logic                              is_encrypted,
    input  wire logic [cumm_pkg::ADDR_W-1:0]       partition_base,
    input  wire logic [cumm_pkg::ADDR_W-1:0]       byte_offset,
    input  wire logic [cumm_pkg::ADDR_W-1:0]       byte_length,
    input  wire logic [cumm_pkg::QIDX_W-1:0]       query_cluster,
    input  wire cumm_pkg::cumm_qstat_t             q_status,
    output logic                                   q_push,
    output cumm_pkg::cumm_req_t                    q_wdata
);

    localparam int AW = cumm_pkg::ADDR_W;
    localparam int SW = cumm_pkg::START_W;
    localparam int XW = cumm_pkg::DIVX_W;
    localparam int PRW = cumm_pkg::PROD_W;
    localparam int CW = cumm_pkg::COUNT_W;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_FIX  = 3'd2;
    localparam logic [2:0] F_SUM  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic          sel_reg, sel_next;         // 0: offset, 1: length
    logic          op_reg, op_next;
    logic          enc_reg, enc_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] off_reg, off_next;
    logic [AW-1:0] len_reg, len_next;
    logic [cumm_pkg::QIDX_W-1:0] qc_reg, qc_next;
    logic [PRW-1:0] prod_reg, prod_next;
    logic [CW-1:0]  qoff_reg, qoff_next;
    logic [4:0]     roff_reg, roff_next;
    logic [CW-1:0]  qlen_reg, qlen_next;
    logic [SW-1:0]  start_reg, start_next;
    logic [SW-1:0]  size_reg, size_next;

    logic [XW-1:0]  div_x;
    logic [CW-1:0]  q0;
    logic [XW:0]    q31;
    logic [XW:0]    r_full;
    logic [5:0]     r0;
    logic [CW-1:0]  q_fix;
    logic [4:0]     r_fix;
    logic [CW:0]    qlen_inc;

    assign div_x = sel_reg ? len_reg[AW-1:cumm_pkg::PAYLOAD_SHIFT]
                           : off_reg[AW-1:cumm_pkg::PAYLOAD_SHIFT];

    // remainder is below 62, so one conditional subtract finishes the division
    always_comb
    begin
        q0     = prod_reg[PRW-1:cumm_pkg::RECIP_SHIFT];
        q31    = {q0, 5'b0} - {5'b0, q0};
        r_full = {1'b0, div_x} - q31;
        r0     = r_full[5:0];
        if (r0 >= cumm_pkg::DIV_31)
        begin
            q_fix = q0 + 1'b1;
            r_fix = 5'(r0 - cumm_pkg::DIV_31);
        end
        else
        begin
            q_fix = q0;
            r_fix = r0[4:0];
        end
    end

    assign qlen_inc = {1'b0, qlen_reg} + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        op_next    = op_reg;
        enc_next   = enc_reg;
        base_next  = base_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        qc_next    = qc_reg;
        prod_next  = prod_reg;
        qoff_next  = qoff_reg;
        roff_next  = roff_reg;
        qlen_next  = qlen_reg;
        start_next = start_reg;
        size_next  = size_reg;
        in_ready   = 1'b0;
        q_push     = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next   = operation;
                    enc_next  = is_encrypted;
                    base_next = partition_base;
                    off_next  = byte_offset;
                    len_next  = byte_length;
                    qc_next   = query_cluster;
                    sel_next  = 1'b0;
                    if (operation == cumm_pkg::OP_MARK && is_encrypted)
                    begin
                        state_next = F_MUL;
                    end
                    else
                    begin
                        state_next = F_SUM;
                    end
                end
            end
            F_MUL:
            begin
                prod_next  = PRW'(div_x) * PRW'(cumm_pkg::RECIP_31);
                state_next = F_FIX;
            end
            F_FIX:
            begin
                if (!sel_reg)
                begin
                    qoff_next  = q_fix;
                    roff_next  = r_fix;
                    sel_next   = 1'b1;
                    state_next = F_MUL;
                end
                else
                begin
                    qlen_next  = q_fix;
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                if (op_reg == cumm_pkg::OP_QUERY)
                begin
                    start_next = {2'b0, qc_reg, 15'b0};
                    size_next  = '0;
                end
                else if (enc_reg)
                begin
                    start_next = {1'b0, qoff_reg, 15'b0} + {2'b0, base_reg};
                    // low part is below 0x7C00, so it fits under the cluster field
                    size_next  = {qlen_inc, roff_reg, off_reg[cumm_pkg::PAYLOAD_SHIFT-1:0]};
                end
                else
                begin
                    start_next = {2'b0, base_reg} + {2'b0, off_reg};
                    size_next  = {2'b0, len_reg};
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_wdata.is_query = (op_reg == cumm_pkg::OP_QUERY);
    assign q_wdata.start    = start_reg;
    assign q_wdata.stop     = {1'b0, start_reg} + {1'b0, size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg   <= sel_next;
        op_reg    <= op_next;
        enc_reg   <= enc_next;
        base_reg  <= base_next;
        off_reg   <= off_next;
        len_reg   <= len_next;
        qc_reg    <= qc_next;
        prod_reg  <= prod_next;
        qoff_reg  <= qoff_next;
        roff_reg  <= roff_next;
        qlen_reg  <= qlen_next;
        start_reg <= start_next;
        size_reg  <= size_next;
    end

endmodule
`default_nettype wire

/* hdl/cumm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cumm_back
// Clears the flag map, walks mark ranges one cluster a cycle, serves queries.
// ----------------------------------------------------------------------------
module cumm_back #(
    parameter int MAX_CLUSTERS = 262144
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire cumm_pkg::cumm_qstat_t               q_status,
    input  wire cumm_pkg::cumm_req_t                 q_head,
    output logic                                     q_pop,
    input  wire logic [cumm_pkg::IMAGE_W-1:0]        limit,
    output logic                                     clearing,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [cumm_pkg::COUNT_W-1:0]             clusters_counted,
    output logic                                     cluster_in_use
);

    localparam int MA = $clog2(MAX_CLUSTERS);
    localparam int SW = cumm_pkg::START_W;
    localparam int EW = cumm_pkg::STOP_W;
    localparam int IW = cumm_pkg::IDX_W;
    localparam int CW = cumm_pkg::COUNT_W;
    localparam int CS = cumm_pkg::CLUSTER_SHIFT;
    localparam logic [IW:0] MAX_EXT = (IW+1)'(MAX_CLUSTERS);
    localparam logic [MA-1:0] CLR_LAST = MA'(MAX_CLUSTERS - 1);

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_WALK  = 3'd2;
    localparam logic [2:0] B_QREAD = 3'd3;
    localparam logic [2:0] B_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [MA-1:0] clr_reg, clr_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [EW-1:0] lim_reg, lim_next;       // min(stop, image limit)
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          inr_reg, inr_next;
    logic          use_reg, use_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_count_reg, out_count_next;
    logic          out_use_reg, out_use_next;

    logic          ram_we;
    logic [MA-1:0] ram_waddr;
    logic          ram_wdata;
    logic          ram_rdata;
    logic [IW-1:0] head_idx;
    logic [IW-1:0] pos_idx;
    logic          head_in_range;
    logic          pos_in_range;
    logic [EW-1:0] limit_ext;

    assign head_idx      = q_head.start[SW-1:CS];
    assign pos_idx       = pos_reg[SW-1:CS];
    assign head_in_range = ({1'b0, head_idx} < MAX_EXT);
    assign pos_in_range  = ({1'b0, pos_idx} < MAX_EXT);
    assign limit_ext     = {2'b0, limit};
    assign ram_wdata     = (state_reg == B_WALK);

    cumm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CLUSTERS)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_idx[MA-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        lim_next       = lim_reg;
        cnt_next       = cnt_reg;
        inr_next       = inr_reg;
        use_next       = use_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_count_next = out_count_reg;
        out_use_next   = out_use_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;

        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.is_query)
                    begin
                        inr_next   = head_in_range;
                        state_next = B_QREAD;
                    end
                    else
                    begin
                        pos_next   = q_head.start;
                        lim_next   = (q_head.stop < limit_ext) ? q_head.stop : limit_ext;
                        cnt_next   = '0;
                        state_next = B_WALK;
                    end
                end
            end
            B_WALK:
            begin
                if ({1'b0, pos_reg} < lim_reg)
                begin
                    // strides past the end of the map are counted but set nothing
                    ram_we    = pos_in_range;
                    ram_waddr = pos_idx[MA-1:0];
                    pos_next  = pos_reg + cumm_pkg::CLUSTER_BYTES;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    use_next   = 1'b0;
                    state_next = B_DONE;
                end
            end
            B_QREAD:
            begin
                cnt_next   = '0;
                use_next   = inr_reg & ram_rdata;
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = cnt_reg;
                    out_use_next   = use_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        lim_reg       <= lim_next;
        cnt_reg       <= cnt_next;
        inr_reg       <= inr_next;
        use_reg       <= use_next;
        out_count_reg <= out_count_next;
        out_use_reg   <= out_use_next;
    end

    assign clearing         = (state_reg == B_CLEAR);
    assign out_valid        = out_valid_reg;
    assign clusters_counted = out_count_reg;
    assign cluster_in_use   = out_use_reg;

    a_walk_below_image: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WALK) && ({1'b0, pos_reg} < lim_reg)
            |-> pos_reg < {1'b0, cumm_pkg::IMAGE_LIMIT})
        else $error("walk position beyond the largest image");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE))
        else $error("request taken while the walker is busy");

endmodule
`default_nettype wire

/* hdl/cluster_usage_map_marker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_usage_map_marker
// One used flag per 32 KiB cluster of a disc image; marks byte ranges and
// answers single-cluster queries.
// ----------------------------------------------------------------------------
//  Port group   Dir  Handshake              Carries
//  in_*         in   in_valid / in_ready    mark or query request
//  out_*        out  out_valid / out_ready  stride count, queried flag
//  cfg_*        in   cfg_write_en           image size in bytes
//
//  A query or a mark is converted in the front, then served by the back; an
//  encrypted mark makes two passes through the shared divide-by-31
//  multiplier. The back walks a mark one stride at a time; the flag RAM's
//  single write port sets one cluster per cycle.
//  After reset the flag RAM is cleared, one entry per cycle, and in_ready
//  stays low until the pass is done.
//  A two-entry queue lets the front take and convert the next request while
//  the back walks or a result waits on out_ready.
// ----------------------------------------------------------------------------
module cluster_usage_map_marker #(
    parameter int MAX_CLUSTERS = 262144
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              operation,
    input  wire logic                              is_encrypted,
    input  wire logic [cumm_pkg::ADDR_W-1:0]       partition_base,
    input  wire logic [cumm_pkg::ADDR_W-1:0]       byte_offset,
    input  wire logic [cumm_pkg::ADDR_W-1:0]       byte_length,
    input  wire logic [cumm_pkg::QIDX_W-1:0]       query_cluster,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [cumm_pkg::COUNT_W-1:0]           clusters_counted,
    output logic                                   cluster_in_use,
    input  wire logic                              cfg_write_en,
    input  wire logic [cumm_pkg::IMAGE_W-1:0]      cfg_write_data
);

    logic [cumm_pkg::IMAGE_W-1:0] image_limit_reg, image_limit_next;
    logic                  front_ready;
    logic                  clearing;
    logic                  q_push;
    logic                  q_pop;
    cumm_pkg::cumm_req_t   q_wdata;
    cumm_pkg::cumm_req_t   q_head;
    cumm_pkg::cumm_qstat_t q_status;

    // saturate on write so the walk bound never exceeds 2^33
    always_comb
    begin
        image_limit_next = image_limit_reg;
        if (cfg_write_en)
        begin
            image_limit_next = (cfg_write_data > cumm_pkg::IMAGE_LIMIT)
                             ? cumm_pkg::IMAGE_LIMIT : cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_limit_reg <= '0;
        end
        else
        begin
            image_limit_reg <= image_limit_next;
        end
    end

    assign in_ready = front_ready & ~clearing;

    cumm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid & ~clearing),
        .in_ready       (front_ready),
        .operation      (operation),
        .is_encrypted   (is_encrypted),
        .partition_base (partition_base),
        .byte_offset    (byte_offset),
        .byte_length    (byte_length),
        .query_cluster  (query_cluster),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    cumm_fifo u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .head   (q_head),
        .status (q_status)
    );

    cumm_back #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_status         (q_status),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .limit            (image_limit_reg),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .clusters_counted (clusters_counted),
        .cluster_in_use   (cluster_in_use)
    );

endmodule
`default_nettype wire

/* dv/tb_cluster_usage_map_marker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cluster_usage_map_marker
// Self-checking bench for the cluster usage map. A scripted pass covers reset
// state, range edges, unaligned starts, encrypted mapping and the image size
// cap. Randomised mark and query requests then run under several image sizes.
// Each result is checked against a pinned value or a flag store kept in the bench.
// ----------------------------------------------------------------------------
module tb_cluster_usage_map_marker;
    import cumm_pkg::*;

    localparam int        MAX_CLUSTERS  = 262144;
    localparam int        HALF_PERIOD   = 6;
    localparam int        HOLD_CYCLES   = 3000;
    localparam int        SETTLE_CYCLES = 16;
    localparam int        STALL_LIMIT   = 1200000;   // clearing pass and a full walk fit
    localparam int        PHASES        = 6;
    localparam int        PHASE_ITEMS   = 300;
    localparam int        NOISE_STRIDES = 1024;
    localparam int        MAX_REPORTS   = 40;
    localparam bit [63:0] PAYLOAD_SIZE  = 64'h7C00;
    localparam bit [63:0] CLUSTER_SIZE  = 64'h8000;
    localparam bit [63:0] SIZE_CAP      = 64'h2_0000_0000;
    localparam bit        PINNED        = 1'b1;
    localparam bit        PREDICTED     = 1'b0;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic              op;
        logic              enc;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] len;
        logic [QIDX_W-1:0] qc;
    } usage_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               used;
    } usage_res_t;

    typedef struct packed {
        usage_req_t req;
        logic       pinned;
        usage_res_t want;
    } offer_t;

    typedef struct packed {
        row_kind_e          kind;
        offer_t             item;
        logic [IMAGE_W-1:0] image;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               out_valid;
    logic               out_ready;
    logic [COUNT_W-1:0] clusters_counted;
    logic               cluster_in_use;
    logic               cfg_write_en;
    logic [IMAGE_W-1:0] cfg_write_data;
    offer_t             on_offer;

    // bench copy of the block state
    bit                 used_map [MAX_CLUSTERS];
    bit [IMAGE_W-1:0]   image_bytes;
    usage_res_t         pending_results [$];
    script_row_t        script [$];

    int      errors;
    int      n_results;
    int      n_marks;
    int      n_queries;
    int      n_used_hits;
    int      holds_done;
    int      quiet_cycles;
    longint  strides_walked;
    bit      steady;
    bit      hold_req;

    cluster_usage_map_marker #(
        .MAX_CLUSTERS(MAX_CLUSTERS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (on_offer.req.op),
        .is_encrypted    (on_offer.req.enc),
        .partition_base  (on_offer.req.base),
        .byte_offset     (on_offer.req.off),
        .byte_length     (on_offer.req.len),
        .query_cluster   (on_offer.req.qc),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .clusters_counted(clusters_counted),
        .cluster_in_use  (cluster_in_use),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly back to back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic bit [63:0] size_limit();
        return (64'(image_bytes) > SIZE_CAP) ? SIZE_CAP : 64'(image_bytes);
    endfunction

    // raw byte range [start, stop) that a mark covers
    function automatic void map_range(input usage_req_t r, output bit [63:0] start,
                                      output bit [63:0] stop);
        if (r.enc)
        begin
            start = (64'(r.off) / PAYLOAD_SIZE) * CLUSTER_SIZE + 64'(r.base);
            stop  = start + (64'(r.len) / PAYLOAD_SIZE + 1) * CLUSTER_SIZE
                    + 64'(r.off) % PAYLOAD_SIZE;
        end
        else
        begin
            start = 64'(r.base) + 64'(r.off);
            stop  = start + 64'(r.len);
        end
    endfunction

    function automatic usage_res_t apply_request(input usage_req_t r);
        usage_res_t res;
        bit [63:0]  pos;
        bit [63:0]  stop;
        bit [63:0]  lim;
        bit [63:0]  strides;
        res = '0;
        if (r.op == OP_QUERY)
        begin
            if (r.qc < MAX_CLUSTERS)
                res.used = used_map[r.qc];
            return res;
        end
        map_range(r, pos, stop);
        lim = size_limit();
        strides = 0;
        // steps from the exact start, so an unaligned range can miss its last cluster
        while (pos < stop && pos < lim)
        begin
            if ((pos >> CLUSTER_SHIFT) < MAX_CLUSTERS)
                used_map[pos >> CLUSTER_SHIFT] = 1'b1;
            pos += CLUSTER_SIZE;
            strides++;
        end
        res.count = strides[COUNT_W-1:0];
        return res;
    endfunction

    function automatic script_row_t mark_row(input logic enc, input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] off,
                                             input logic [ADDR_W-1:0] len,
                                             input bit pinned, input int count);
        script_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item.req.op = OP_MARK;
        row.item.req.enc = enc;
        row.item.req.base = base;
        row.item.req.off = off;
        row.item.req.len = len;
        row.item.pinned = pinned;
        row.item.want.count = COUNT_W'(count);
        return row;
    endfunction

    function automatic script_row_t query_row(input logic [QIDX_W-1:0] qc, input bit pinned,
                                              input logic used);
        script_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item.req.op = OP_QUERY;
        row.item.req.qc = qc;
        row.item.pinned = pinned;
        row.item.want.used = used;
        return row;
    endfunction

    function automatic script_row_t size_row(input logic [IMAGE_W-1:0] image);
        script_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.image = image;
        return row;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: result %0d, %s: got %0d, expected %0d",
                     $time, n_results, field, got, want);
    endtask

    task automatic offer_item(input offer_t o);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        on_offer <= o;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_image_size(input logic [IMAGE_W-1:0] v);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        image_bytes = v;
    endtask

    task automatic run_script(input int first, input int last);
        for (int i = first; i < last; i++)
        begin
            if (script[i].kind == ROW_CFG)
                write_image_size(script[i].image);
            else
                offer_item(script[i].item);
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        usage_res_t predicted;
        usage_res_t want;
        if (rst_n && in_valid && in_ready)
        begin
            predicted = apply_request(on_offer.req);
            if (on_offer.req.op == OP_QUERY)
            begin
                n_queries++;
                n_used_hits += predicted.used;
            end
            else
            begin
                n_marks++;
                strides_walked += predicted.count;
            end
            if (on_offer.pinned)
                predicted = on_offer.want;
            pending_results.push_back(predicted);
        end
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", clusters_counted,
                                cluster_in_use);
            else
            begin
                want = pending_results.pop_front();
                if (clusters_counted !== want.count)
                    report_mismatch("clusters_counted", clusters_counted, want.count);
                if (cluster_in_use !== want.used)
                    report_mismatch("cluster_in_use", cluster_in_use, want.used);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : receiver
        int stall_left;
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // long hold-off so the queue fills and in_ready drops
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
                holds_done++;
            end
            else if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        usage_req_t         r;
        offer_t             o;
        bit [63:0]          lim;
        bit [63:0]          start;
        bit [63:0]          stop;
        bit [63:0]          s;
        bit [63:0]          est;
        bit [63:0]          last_cluster;
        logic [IMAGE_W-1:0] img_size;
        int                 sweep_row;
        int                 pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        on_offer = '0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        last_cluster = 0;

        // after reset: store clear, image size zero
        script.push_back(query_row(18'd0, PINNED, 1'b0));
        script.push_back(query_row(18'h3FFFF, PINNED, 1'b0));
        script.push_back(mark_row(1'b0, 0, 0, 33'h1_0000, PINNED, 0));
        script.push_back(size_row(34'h20_0000));              // 64 clusters
        script.push_back(mark_row(1'b0, 0, 0, 0, PINNED, 0));
        script.push_back(mark_row(1'b0, 0, 0, 33'h8000, PINNED, 1));
        script.push_back(query_row(18'd0, PINNED, 1'b1));
        // unaligned start: cluster 1 lies in range but is never stepped on
        script.push_back(mark_row(1'b0, 33'h4000, 0, 33'h8000, PINNED, 1));
        script.push_back(query_row(18'd1, PINNED, 1'b0));
        script.push_back(mark_row(1'b0, '1, '1, '1, PINNED, 0));
        // walk cut short by the image end
        script.push_back(mark_row(1'b0, 33'h1F_0000, 0, 33'h10_0000, PINNED, 2));
        script.push_back(query_row(18'd63, PINNED, 1'b1));
        script.push_back(query_row(18'd64, PINNED, 1'b0));
        script.push_back(mark_row(1'b1, 33'h4_0000, 33'h1_7500, 33'hF7FF, PREDICTED, 0));
        script.push_back(mark_row(1'b1, 0, 0, 0, PREDICTED, 0));
        script.push_back(mark_row(1'b1, '1, '1, '1, PREDICTED, 0));
        // sizes above 8 GiB saturate
        script.push_back(size_row('1));
        script.push_back(mark_row(1'b0, 33'h1_FFFF_8000, 0, 33'h1_0000, PINNED, 1));
        script.push_back(query_row(18'h3FFFF, PINNED, 1'b1));
        script.push_back(mark_row(1'b0, 33'h1_0000_0000, 33'h1_0000_0000, 33'd1, PINNED, 0));
        script.push_back(size_row(34'h2_0000_0000));
        script.push_back(mark_row(1'b0, 33'h1_FFFF_0000, 33'h7FFF, 33'h2_0000, PREDICTED, 0));
        script.push_back(mark_row(1'b1, 33'h1234_5678, 33'h30_7005, 33'h3_644D, PREDICTED, 0));
        script.push_back(query_row(18'h3FFFE, PREDICTED, 1'b0));
        // closing sweep over the whole image, the largest count there is
        sweep_row = script.size();
        script.push_back(size_row('1));
        script.push_back(mark_row(1'b0, 0, 0, '1, PINNED, 32'h4_0000));
        script.push_back(query_row(18'd0, PINNED, 1'b1));
        script.push_back(query_row(18'h1FFFF, PINNED, 1'b1));
        script.push_back(query_row(18'h3FFFF, PINNED, 1'b1));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_script(0, sweep_row);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: img_size = IMAGE_W'(64'($urandom_range(16, 200)) * CLUSTER_SIZE
                                       + $urandom_range(0, 32'h7FFF));
                1: img_size = {2'($urandom_range(0, 3)), 32'($urandom)};
                2: img_size = IMAGE_W'(SIZE_CAP);
                3: img_size = IMAGE_W'($urandom_range(1, 32'h0FFF_FFFF));
                4: img_size = IMAGE_W'(CLUSTER_SIZE + $urandom_range(0, 32'h7FFF));
                default: img_size = '1;
            endcase
            write_image_size(img_size);
            steady = (ph == 2);
            if (ph == 1)
                hold_req = 1'b1;
            lim = size_limit();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = '0;
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    r.op = OP_QUERY;
                    if ($urandom_range(0, 1))
                        r.qc = QIDX_W'(last_cluster + $urandom_range(0, 2));
                    else
                        r.qc = QIDX_W'($urandom);
                end
                else if (pick < 62)
                begin
                    // plain range starting inside the image
                    r.op = OP_MARK;
                    s = (lim == 0) ? 64'd0 : rand64() % lim;
                    r.off = ADDR_W'(rand64() % (s + 1));
                    r.base = ADDR_W'(s - 64'(r.off));
                    if ($urandom_range(0, 19) == 0)
                        r.len = ADDR_W'($urandom_range(0, 300 * 32'h8000));
                    else
                        r.len = ADDR_W'($urandom_range(0, 6 * 32'h8000));
                    last_cluster = s >> CLUSTER_SHIFT;
                end
                else if (pick < 88)
                begin
                    // encrypted: whole payload blocks plus a tail
                    r.op = OP_MARK;
                    r.enc = 1'b1;
                    r.base = ADDR_W'((lim == 0) ? 64'd0 : rand64() % lim);
                    r.off = ADDR_W'(64'($urandom_range(0, 40)) * PAYLOAD_SIZE
                                    + $urandom_range(0, 32'h7BFF));
                    r.len = ADDR_W'($urandom_range(0, 32'h1_F000));
                    last_cluster = (64'(r.base) + (64'(r.off) / PAYLOAD_SIZE) * CLUSTER_SIZE)
                                   >> CLUSTER_SHIFT;
                end
                else
                begin
                    // full-width noise, redrawn until the walk stays short
                    r.op = OP_MARK;
                    do
                    begin
                        r.enc = 1'($urandom_range(0, 1));
                        r.base = ADDR_W'(rand64());
                        r.off = ADDR_W'(rand64());
                        r.len = ADDR_W'(rand64());
                        map_range(r, start, stop);
                        if (stop > lim)
                            stop = lim;
                        est = (stop > start) ? (stop - start) / CLUSTER_SIZE : 64'd0;
                    end
                    while (est > NOISE_STRIDES);
                end
                o = '0;
                o.req = r;
                offer_item(o);
            end
        end
        steady = 1'b0;

        run_script(sweep_row, script.size());
        drain();

        $display("Ran %0d requests: %0d marks walking %0d strides, %0d queries (%0d in use).",
                 n_marks + n_queries, n_marks, strides_walked, n_queries, n_used_hits);
        $display("Image sizes from zero past the 8 GiB cap, %0d output hold-off(s), %0d mismatches.",
                 holds_done, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
